### hw/rtl/acpu_pkg.sv
// Shared constants, codes and types of the accumulator CPU core.
package acpu_pkg;

	// Storage sizes. Both depths are powers of two, so an index is a plain part-select.
	localparam int MEM_DEPTH = 2048;
	localparam int IO_DEPTH  = 32;
	localparam int MEM_AW    = $clog2(MEM_DEPTH);
	localparam int IO_AW     = $clog2(IO_DEPTH);

	// The clearing sweep after reset covers the deeper of the two stores.
	localparam int CLR_DEPTH = (MEM_DEPTH > IO_DEPTH) ? MEM_DEPTH : IO_DEPTH;
	localparam int CLR_AW    = $clog2(CLR_DEPTH);

	// Fixed field widths.
	localparam int ADDR_W = 11;
	localparam int MODE_W = 3;
	localparam int DATA_W = 8;
	localparam int OPC_W  = 5;
	localparam int FLAG_W = 4;

	// Item modes.
	localparam logic [MODE_W-1:0] MODE_WR_MEM = 3'd0;
	localparam logic [MODE_W-1:0] MODE_RD_MEM = 3'd1;
	localparam logic [MODE_W-1:0] MODE_WR_IO  = 3'd2;
	localparam logic [MODE_W-1:0] MODE_RD_IO  = 3'd3;
	localparam logic [MODE_W-1:0] MODE_STEP   = 3'd4;

	// Opcodes.
	localparam logic [OPC_W-1:0] OP_WM   = 5'd1;
	localparam logic [OPC_W-1:0] OP_RM   = 5'd2;
	localparam logic [OPC_W-1:0] OP_BR   = 5'd3;
	localparam logic [OPC_W-1:0] OP_RIO  = 5'd4;
	localparam logic [OPC_W-1:0] OP_WIO  = 5'd5;
	localparam logic [OPC_W-1:0] OP_WB   = 5'd6;
	localparam logic [OPC_W-1:0] OP_WIB  = 5'd7;
	localparam logic [OPC_W-1:0] OP_WACC = 5'd9;
	localparam logic [OPC_W-1:0] OP_RACC = 5'd11;
	localparam logic [OPC_W-1:0] OP_SWAP = 5'd14;
	localparam logic [OPC_W-1:0] OP_BRLT = 5'd17;
	localparam logic [OPC_W-1:0] OP_BRGT = 5'd18;
	localparam logic [OPC_W-1:0] OP_BRNE = 5'd19;
	localparam logic [OPC_W-1:0] OP_BRE  = 5'd20;
	localparam logic [OPC_W-1:0] OP_SHR  = 5'd21;
	localparam logic [OPC_W-1:0] OP_SHL  = 5'd22;
	localparam logic [OPC_W-1:0] OP_XOR  = 5'd23;
	localparam logic [OPC_W-1:0] OP_NOT  = 5'd24;
	localparam logic [OPC_W-1:0] OP_OR   = 5'd25;
	localparam logic [OPC_W-1:0] OP_AND  = 5'd26;
	localparam logic [OPC_W-1:0] OP_MUL  = 5'd27;
	localparam logic [OPC_W-1:0] OP_SUB  = 5'd29;
	localparam logic [OPC_W-1:0] OP_ADD  = 5'd30;
	localparam logic [OPC_W-1:0] OP_EOP  = 5'd31;

	// Bit positions in the flag word.
	localparam int FLAG_ZF = 0;
	localparam int FLAG_CF = 1;
	localparam int FLAG_SF = 2;
	localparam int FLAG_OF = 3;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic              clr;
		logic [CLR_AW-1:0] clr_addr;
		logic              accept;
		logic              fetch_hi;
		logic              fetch_lo;
		logic              exec;
		logic              out_load;
	} acpu_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic halted;
	} acpu_stat_t;

	// Result of the arithmetic and logic unit.
	typedef struct packed {
		logic [DATA_W-1:0] acc;
		logic [FLAG_W-1:0] flags;
		logic              take;
	} acpu_alu_res_t;

endpackage

### hw/rtl/acpu_alu.sv
// Arithmetic, logic, shift and compare unit of the accumulator CPU core.
module acpu_alu (
	input  logic [acpu_pkg::OPC_W-1:0]  opc,
	input  logic [acpu_pkg::DATA_W-1:0] acc,
	input  logic [acpu_pkg::DATA_W-1:0] mbr,
	input  logic [acpu_pkg::FLAG_W-1:0] flags,
	output acpu_pkg::acpu_alu_res_t     res
);
	import acpu_pkg::*;

	logic [15:0]       prod;
	logic [15:0]       wide;
	logic [DATA_W-1:0] lres;
	logic [FLAG_W-1:0] aflags;

	assign prod = 16'(acc) * 16'(mbr);

	always_comb begin
		case (opc)
			OP_MUL:  wide = prod;
			OP_ADD:  wide = 16'(acc) + 16'(mbr);
			default: wide = 16'(acc) + 16'(8'(8'd0 - mbr));
		endcase

		aflags          = '0;
		aflags[FLAG_ZF] = (wide[7:0] == 8'd0);
		aflags[FLAG_CF] = |wide[15:8];
		aflags[FLAG_SF] = wide[7];
		aflags[FLAG_OF] = |wide[15:8];

		case (opc)
			OP_XOR:  lres = acc ^ mbr;
			OP_OR:   lres = acc | mbr;
			OP_AND:  lres = acc & mbr;
			default: lres = ~acc;
		endcase

		res.acc   = acc;
		res.flags = flags;
		res.take  = 1'b0;

		unique case (opc) inside
			OP_WACC: begin
				res.acc = mbr;
			end
			OP_ADD, OP_SUB, OP_MUL: begin
				res.acc   = wide[7:0];
				res.flags = aflags;
			end
			OP_BRLT, OP_BRGT, OP_BRNE, OP_BRE: begin
				res.acc   = wide[7:0];
				res.flags = aflags;
				case (opc)
					OP_BRE:  res.take = aflags[FLAG_ZF];
					OP_BRNE: res.take = !aflags[FLAG_ZF];
					OP_BRGT: res.take = !aflags[FLAG_SF] && !aflags[FLAG_ZF];
					default: res.take = aflags[FLAG_SF];
				endcase
			end
			OP_SHR: begin
				res.acc            = {1'b0, acc[7:1]};
				res.flags[FLAG_CF] = acc[0];
			end
			OP_SHL: begin
				res.acc            = {acc[6:0], 1'b0};
				res.flags[FLAG_CF] = acc[7];
			end
			OP_XOR, OP_NOT, OP_OR, OP_AND: begin
				res.acc            = lres;
				res.flags[FLAG_ZF] = (lres == 8'd0);
			end
			default: begin
			end
		endcase
	end

endmodule

### hw/rtl/acpu_ctrl.sv
// Controller state machine of the accumulator CPU core.
module acpu_ctrl (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic [acpu_pkg::MODE_W-1:0] in_mode,
	output logic                        out_valid,
	input  logic                        out_stall,
	input  acpu_pkg::acpu_stat_t        stat,
	output acpu_pkg::acpu_cmd_t         cmd
);
	import acpu_pkg::*;

	localparam logic [2:0] ST_CLEAR = 3'd0;
	localparam logic [2:0] ST_IDLE  = 3'd1;
	localparam logic [2:0] ST_FHI   = 3'd2;
	localparam logic [2:0] ST_FLO   = 3'd3;
	localparam logic [2:0] ST_EXEC  = 3'd4;
	localparam logic [2:0] ST_RESP  = 3'd5;

	localparam logic [CLR_AW-1:0] CLR_LAST = CLR_AW'(CLR_DEPTH - 1);

	logic [2:0]        state_q;
	logic [2:0]        state_d;
	logic [CLR_AW-1:0] clr_q;
	logic              out_valid_q;

	always_comb begin
		state_d      = state_q;
		cmd          = '0;
		cmd.clr_addr = clr_q;
		unique case (state_q)
			ST_CLEAR: begin
				cmd.clr = 1'b1;
				if (clr_q == CLR_LAST) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (in_valid) begin
					cmd.accept = 1'b1;
					if (in_mode == MODE_STEP && !stat.halted) begin
						state_d = ST_FHI;
					end else begin
						state_d = ST_RESP;
					end
				end
			end
			ST_FHI: begin
				cmd.fetch_hi = 1'b1;
				state_d      = ST_FLO;
			end
			ST_FLO: begin
				cmd.fetch_lo = 1'b1;
				state_d      = ST_EXEC;
			end
			ST_EXEC: begin
				cmd.exec = 1'b1;
				state_d  = ST_RESP;
			end
			ST_RESP: begin
				if (!out_valid_q || !out_stall) begin
					cmd.out_load = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			clr_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			out_valid_q <= cmd.out_load || (out_valid_q && out_stall);
			if (state_q == ST_CLEAR) begin
				clr_q <= clr_q + 1'b1;
			end
		end
	end

	assign in_stall  = (state_q != ST_IDLE);
	assign out_valid = out_valid_q;

endmodule

### hw/rtl/acpu_dpath.sv
// Datapath of the accumulator CPU core: memories, machine registers and result register.
module acpu_dpath (
	input  logic                        clk,
	input  logic                        arst_n,
	input  acpu_pkg::acpu_cmd_t         cmd,
	output acpu_pkg::acpu_stat_t        stat,
	input  logic [acpu_pkg::MODE_W-1:0] mode,
	input  logic [acpu_pkg::ADDR_W-1:0] address,
	input  logic [acpu_pkg::DATA_W-1:0] data,
	output logic [acpu_pkg::DATA_W-1:0] read_data,
	output logic [acpu_pkg::ADDR_W-1:0] pc_value,
	output logic [acpu_pkg::DATA_W-1:0] acc_value,
	output logic [acpu_pkg::DATA_W-1:0] mbr_value,
	output logic [acpu_pkg::DATA_W-1:0] iobr_value,
	output logic                        zero_flag,
	output logic                        carry_flag,
	output logic                        sign_flag,
	output logic                        overflow_flag,
	output logic                        halted,
	output logic                        bad_opcode
);
	import acpu_pkg::*;

	logic [DATA_W-1:0] mem_q [MEM_DEPTH];
	logic [DATA_W-1:0] io_q [IO_DEPTH];
	logic [DATA_W-1:0] mem_rd_q;
	logic [DATA_W-1:0] io_rd_q;

	logic              mem_re;
	logic              mem_we;
	logic [MEM_AW-1:0] mem_ra;
	logic [MEM_AW-1:0] mem_wa;
	logic [DATA_W-1:0] mem_wd;
	logic              io_re;
	logic              io_we;
	logic [IO_AW-1:0]  io_ra;
	logic [IO_AW-1:0]  io_wa;
	logic [DATA_W-1:0] io_wd;

	logic [MODE_W-1:0] mode_q;
	logic [DATA_W-1:0] hi_q;
	logic [15:0]       ir_q;

	logic [ADDR_W-1:0] pc_q;
	logic [DATA_W-1:0] acc_q;
	logic [DATA_W-1:0] mbr_q;
	logic [DATA_W-1:0] iobr_q;
	logic [FLAG_W-1:0] flags_q;
	logic              halt_q;
	logic              bad_q;

	logic [DATA_W-1:0] read_data_q;
	logic [ADDR_W-1:0] pc_value_q;
	logic [DATA_W-1:0] acc_value_q;
	logic [DATA_W-1:0] mbr_value_q;
	logic [DATA_W-1:0] iobr_value_q;
	logic [FLAG_W-1:0] flags_value_q;
	logic              halted_q;
	logic              bad_opcode_q;

	logic [ADDR_W-1:0] opd_lo;
	logic [ADDR_W-1:0] opd;
	logic [OPC_W-1:0]  opc;
	logic [ADDR_W-1:0] pc_inc1;
	logic [ADDR_W-1:0] pc_inc2;
	acpu_alu_res_t     alu_res;

	// Operand of the word whose low byte has just arrived from memory.
	assign opd_lo  = {hi_q[2:0], mem_rd_q};
	assign opd     = ir_q[ADDR_W-1:0];
	assign opc     = ir_q[15:11];
	assign pc_inc1 = pc_q + 11'd1;
	assign pc_inc2 = pc_q + 11'd2;

	acpu_alu u_alu (
		.opc   (opc),
		.acc   (acc_q),
		.mbr   (mbr_q),
		.flags (flags_q),
		.res   (alu_res)
	);

	always_comb begin
		mem_re = 1'b0;
		mem_ra = address[MEM_AW-1:0];
		if (cmd.accept && mode == MODE_RD_MEM) begin
			mem_re = 1'b1;
		end else if (cmd.accept && mode == MODE_STEP) begin
			mem_re = 1'b1;
			mem_ra = pc_q[MEM_AW-1:0];
		end else if (cmd.fetch_hi) begin
			mem_re = 1'b1;
			mem_ra = pc_inc1[MEM_AW-1:0];
		end else if (cmd.fetch_lo) begin
			mem_re = 1'b1;
			mem_ra = opd_lo[MEM_AW-1:0];
		end

		mem_we = 1'b0;
		mem_wa = opd[MEM_AW-1:0];
		mem_wd = mbr_q;
		if (cmd.clr) begin
			mem_we = 1'b1;
			mem_wa = cmd.clr_addr[MEM_AW-1:0];
			mem_wd = '0;
		end else if (cmd.accept && mode == MODE_WR_MEM) begin
			mem_we = 1'b1;
			mem_wa = address[MEM_AW-1:0];
			mem_wd = data;
		end else if (cmd.exec && opc == OP_WM) begin
			mem_we = 1'b1;
		end

		io_re = 1'b0;
		io_ra = address[IO_AW-1:0];
		if (cmd.accept && mode == MODE_RD_IO) begin
			io_re = 1'b1;
		end else if (cmd.fetch_lo) begin
			io_re = 1'b1;
			io_ra = opd_lo[IO_AW-1:0];
		end

		io_we = 1'b0;
		io_wa = opd[IO_AW-1:0];
		io_wd = iobr_q;
		if (cmd.clr) begin
			io_we = 1'b1;
			io_wa = cmd.clr_addr[IO_AW-1:0];
			io_wd = '0;
		end else if (cmd.accept && mode == MODE_WR_IO) begin
			io_we = 1'b1;
			io_wa = address[IO_AW-1:0];
			io_wd = data;
		end else if (cmd.exec && opc == OP_WIO) begin
			io_we = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem_q[mem_wa] <= mem_wd;
		end
		if (mem_re) begin
			mem_rd_q <= mem_q[mem_ra];
		end
	end

	always_ff @(posedge clk) begin
		if (io_we) begin
			io_q[io_wa] <= io_wd;
		end
		if (io_re) begin
			io_rd_q <= io_q[io_ra];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			mode_q <= mode;
		end
		if (cmd.fetch_hi) begin
			hi_q <= mem_rd_q;
		end
		if (cmd.fetch_lo) begin
			ir_q <= {hi_q, mem_rd_q};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q    <= '0;
			acc_q   <= '0;
			mbr_q   <= '0;
			iobr_q  <= '0;
			flags_q <= '0;
			halt_q  <= 1'b0;
			bad_q   <= 1'b0;
		end else if (cmd.exec) begin
			pc_q    <= (alu_res.take || opc == OP_BR) ? opd : pc_inc2;
			acc_q   <= alu_res.acc;
			flags_q <= alu_res.flags;
			unique case (opc) inside
				OP_RM: begin
					mbr_q <= mem_rd_q;
				end
				OP_RIO: begin
					iobr_q <= io_rd_q;
				end
				OP_WB: begin
					mbr_q <= opd[7:0];
				end
				OP_WIB: begin
					iobr_q <= opd[7:0];
				end
				OP_RACC: begin
					mbr_q <= acc_q;
				end
				OP_SWAP: begin
					mbr_q  <= iobr_q;
					iobr_q <= mbr_q;
				end
				OP_EOP: begin
					halt_q <= 1'b1;
				end
				OP_WM, OP_BR, OP_WIO, OP_WACC, OP_BRLT, OP_BRGT, OP_BRNE, OP_BRE,
				OP_SHR, OP_SHL, OP_XOR, OP_NOT, OP_OR, OP_AND, OP_MUL, OP_SUB,
				OP_ADD: begin
				end
				default: begin
					halt_q <= 1'b1;
					bad_q  <= 1'b1;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			if (mode_q == MODE_RD_MEM) begin
				read_data_q <= mem_rd_q;
			end else if (mode_q == MODE_RD_IO) begin
				read_data_q <= io_rd_q;
			end else begin
				read_data_q <= '0;
			end
			pc_value_q    <= pc_q;
			acc_value_q   <= acc_q;
			mbr_value_q   <= mbr_q;
			iobr_value_q  <= iobr_q;
			flags_value_q <= flags_q;
			halted_q      <= halt_q;
			bad_opcode_q  <= bad_q;
		end
	end

	assign stat.halted   = halt_q;
	assign read_data     = read_data_q;
	assign pc_value      = pc_value_q;
	assign acc_value     = acc_value_q;
	assign mbr_value     = mbr_value_q;
	assign iobr_value    = iobr_value_q;
	assign zero_flag     = flags_value_q[FLAG_ZF];
	assign carry_flag    = flags_value_q[FLAG_CF];
	assign sign_flag     = flags_value_q[FLAG_SF];
	assign overflow_flag = flags_value_q[FLAG_OF];
	assign halted        = halted_q;
	assign bad_opcode    = bad_opcode_q;

endmodule

### hw/rtl/accumulator_cpu_core.sv
// Top level of the 8-bit accumulator CPU core: controller plus datapath.
//
// Usage: an input beat carries mode, address and data and is taken when
// in_valid is high and in_stall is low. Every input beat yields exactly one
// output beat, presented on out_valid and held while out_stall is high.
// The output beat carries the read byte (zero outside the read modes) and a
// snapshot of PC, ACC, MBR, IOBR, the four flags and the stop status.
// Memory and I/O loads or reads, unused modes and steps of a stopped machine
// pass through the accept cycle and the response state, which loads the
// result register that drives out_valid. An execute beat passes through the
// accept cycle and the next one, which issue the two fetch reads on the
// single data memory read port, a decode state that issues the operand read,
// an execute state and the response state. A new input beat is taken in the
// cycle after the result register is loaded, even if the receiver has not yet
// taken the previous one. After reset both memories are swept to zero, one
// address per cycle, over 2048 addresses (the larger store depth); in_stall
// stays high during the sweep. A stalled receiver holds the block in its
// response state once the result register is full, which in turn keeps
// in_stall high.
module accumulator_cpu_core (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic [acpu_pkg::MODE_W-1:0] mode,
	input  logic [acpu_pkg::ADDR_W-1:0] address,
	input  logic [acpu_pkg::DATA_W-1:0] data,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic [acpu_pkg::DATA_W-1:0] read_data,
	output logic [acpu_pkg::ADDR_W-1:0] pc_value,
	output logic [acpu_pkg::DATA_W-1:0] acc_value,
	output logic [acpu_pkg::DATA_W-1:0] mbr_value,
	output logic [acpu_pkg::DATA_W-1:0] iobr_value,
	output logic                        zero_flag,
	output logic                        carry_flag,
	output logic                        sign_flag,
	output logic                        overflow_flag,
	output logic                        halted,
	output logic                        bad_opcode
);
	import acpu_pkg::*;

	// Command and status between the sequencer and the datapath.
	acpu_cmd_t  cmd;
	acpu_stat_t stat;

	// The controller sequences each beat: clear sweep, accept, fetch,
	// execute and response hand-off.
	acpu_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_mode   (mode),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.stat      (stat),
		.cmd       (cmd)
	);

	// The datapath holds both memories, the machine registers and the
	// result register that the output beat is presented from.
	acpu_dpath u_dpath (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.stat          (stat),
		.mode          (mode),
		.address       (address),
		.data          (data),
		.read_data     (read_data),
		.pc_value      (pc_value),
		.acc_value     (acc_value),
		.mbr_value     (mbr_value),
		.iobr_value    (iobr_value),
		.zero_flag     (zero_flag),
		.carry_flag    (carry_flag),
		.sign_flag     (sign_flag),
		.overflow_flag (overflow_flag),
		.halted        (halted),
		.bad_opcode    (bad_opcode)
	);

endmodule
